### rtl/core/b64c_pkg.sv
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_ERR
    } job_kind_t;

    // one group of work handed from front to back
    typedef struct packed {
        job_kind_t       kind;
        logic [23:0]     bits;      // encode: left-aligned triple, decode: 24 decoded bits
        logic [1:0]      pad;       // encode: bit 0 pads char 2, bit 1 pads char 3
        logic [3:0][1:0] sel;       // slot emitted at each result position
        logic [1:0]      last_idx;  // position of the final result of this job
        logic            last;      // job closes the stream
    } job_t;

    // six-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // character to {valid, six-bit value}; pad counts as zero
    function automatic logic [6:0] dec_char(input logic [7:0] c);
        logic [6:0] r;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end else if (c == PAD_CHAR) begin
            r = {1'b1, 6'd0};
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

### rtl/core/b64c_front.sv
module b64c_front
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_in,
    input  logic       last_in,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    logic        dir_reg, dir_next;
    logic [23:0] gb_reg, gb_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pad_reg, pad_next;
    logic        err_reg, err_next;

    logic        accept;
    logic [2:0]  have;
    logic [23:0] enc_bits;
    logic [23:0] dec_bits;
    logic [6:0]  cv;
    logic        is_pad;
    logic [1:0]  pad_v;
    logic        err_v;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign have   = {1'b0, cnt_reg} + 3'd1;
    assign enc_bits = {gb_reg[15:0], data_in};
    assign cv       = dec_char(data_in);
    assign dec_bits = {gb_reg[17:0], cv[5:0]};
    assign is_pad   = (data_in == PAD_CHAR);

    always_comb
    begin
        dir_next = dir_reg;
        gb_next  = gb_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        q_push   = 1'b0;
        q_job    = '0;
        pad_v    = pad_reg;
        err_v    = err_reg;
        if (cfg_we) begin
            dir_next = cfg_wdata;
            gb_next  = '0;
            cnt_next = '0;
            pad_next = '0;
            err_next = 1'b0;
        end else if (accept) begin
            if (!dir_reg) begin
                if (have < 3'd3 && !last_in) begin
                    gb_next  = enc_bits;
                    cnt_next = have[1:0];
                end else begin
                    q_push        = 1'b1;
                    q_job.kind    = JOB_ENC;
                    case (have)
                        3'd1:    q_job.bits = {enc_bits[7:0], 16'h0000};
                        3'd2:    q_job.bits = {enc_bits[15:0], 8'h00};
                        default: q_job.bits = enc_bits;
                    endcase
                    q_job.pad[0]   = (have < 3'd2);
                    q_job.pad[1]   = (have < 3'd3);
                    q_job.sel      = {2'd3, 2'd2, 2'd1, 2'd0};
                    q_job.last_idx = 2'd3;
                    q_job.last     = last_in;
                    gb_next  = '0;
                    cnt_next = '0;
                    pad_next = '0;
                    err_next = 1'b0;
                end
            end else begin
                if (!err_reg) begin
                    if (!cv[6]) begin
                        err_v = 1'b1;
                    end else begin
                        pad_v = pad_reg | {(have == 3'd4) && is_pad, (have == 3'd3) && is_pad};
                        if (have == 3'd4) begin
                            q_push      = 1'b1;
                            q_job.kind  = JOB_DEC;
                            q_job.bits  = dec_bits;
                            q_job.last  = last_in;
                            q_job.sel[0] = 2'd0;
                            case (pad_v)
                                2'b00:
                                begin
                                    q_job.sel[1]   = 2'd1;
                                    q_job.sel[2]   = 2'd2;
                                    q_job.last_idx = 2'd2;
                                end
                                2'b01:
                                begin
                                    q_job.sel[1]   = 2'd2;
                                    q_job.last_idx = 2'd1;
                                end
                                2'b10:
                                begin
                                    q_job.sel[1]   = 2'd1;
                                    q_job.last_idx = 2'd1;
                                end
                                default: q_job.last_idx = 2'd0;
                            endcase
                            gb_next  = '0;
                            cnt_next = '0;
                            pad_next = '0;
                        end else begin
                            gb_next  = dec_bits;
                            cnt_next = have[1:0];
                            pad_next = pad_v;
                            if (last_in) begin
                                err_v = 1'b1;
                            end
                        end
                    end
                end
                err_next = err_v;
                if (last_in) begin
                    if (err_v) begin
                        q_push         = 1'b1;
                        q_job          = '0;
                        q_job.kind     = JOB_ERR;
                        q_job.last     = 1'b1;
                        q_job.last_idx = 2'd0;
                    end
                    gb_next  = '0;
                    cnt_next = '0;
                    pad_next = '0;
                    err_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dir_reg <= 1'b0;
            gb_reg  <= '0;
            cnt_reg <= '0;
            pad_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            dir_reg <= dir_next;
            gb_reg  <= gb_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
        end
    end

endmodule

### rtl/core/b64c_queue.sv
module b64c_queue
    import b64c_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic full,
    input  logic rd_en,
    output logic head_valid,
    output job_t head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr;
    logic          do_rd;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = store_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            store_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/b64c_back.sv
module b64c_back
    import b64c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] data_out,
    output logic       last_out,
    output logic       error_out,
    output logic [1:0] slot_idx
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;
    logic [1:0] idx_reg, idx_next;

    logic       advance;
    logic       final_beat;
    logic [1:0] slot;
    logic [5:0] six;
    logic [7:0] byte_v;

    assign advance    = head_valid && (!valid_reg || pop);
    assign final_beat = (idx_reg == head_job.last_idx);
    assign q_pop      = advance && final_beat;
    assign slot       = head_job.sel[idx_reg];

    always_comb
    begin
        case (slot)
            2'd0:    six = head_job.bits[23:18];
            2'd1:    six = head_job.bits[17:12];
            2'd2:    six = head_job.bits[11:6];
            default: six = head_job.bits[5:0];
        endcase
        case (slot)
            2'd0:    byte_v = head_job.bits[23:16];
            2'd1:    byte_v = head_job.bits[15:8];
            2'd2:    byte_v = head_job.bits[7:0];
            default: byte_v = 8'h00;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        if (advance) begin
            valid_next = 1'b1;
            last_next  = head_job.last && final_beat;
            err_next   = 1'b0;
            case (head_job.kind)
                JOB_ENC:
                begin
                    if ((slot == 2'd2 && head_job.pad[0]) || (slot == 2'd3 && head_job.pad[1]))
                    begin
                        data_next = PAD_CHAR;
                    end else begin
                        data_next = enc_char(six);
                    end
                end
                JOB_DEC: data_next = byte_v;
                JOB_ERR:
                begin
                    data_next = 8'h00;
                    err_next  = 1'b1;
                end
                default: data_next = 8'h00;
            endcase
            idx_next = final_beat ? 2'd0 : idx_reg + 2'd1;
        end else if (pop) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign empty     = !valid_reg;
    assign data_out  = data_reg;
    assign last_out  = last_reg;
    assign error_out = err_reg;
    assign slot_idx  = idx_reg;

endmodule

### rtl/core/base64_stream_codec_top.sv
// channel   direction  handshake                 payload
// input     in         push / full               data_in[7:0], last_in
// result    out        pop / empty               data_out[7:0], last_out, error_out
// config    in         direction_we (no wait)    direction_wdata
//
// the front takes one beat per cycle while the job queue has room; a job holds one group
// the back emits one result beat per cycle from its output register while pop keeps up,
// so encode takes three input beats per four result beats and decode takes one input
// beat per cycle; a group's job is queued, then its first result is registered
// rst_n clears all control state at once; direction resets to encode
// a stall on pop fills the output register, then the queue, then raises full
module base64_stream_codec_top
    import b64c_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_in,
    input  logic       last_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_out,
    output logic       last_out,
    output logic       error_out,
    input  logic       direction_we,
    input  logic       direction_wdata
);

    // front to queue
    logic q_push;
    job_t q_job;
    logic q_full;

    // queue to back
    logic q_pop;
    logic head_valid;
    job_t head_job;
    logic [1:0] slot_idx;

    // front: gathers bytes or characters into groups, tracks padding and errors
    b64c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_in   (data_in),
        .last_in   (last_in),
        .cfg_we    (direction_we),
        .cfg_wdata (direction_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // short job queue lets front and back stall on their own
    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_push),
        .wr_job     (q_job),
        .full       (q_full),
        .rd_en      (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: walks the slots of each job, one result beat per cycle while pop keeps up
    b64c_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .data_out   (data_out),
        .last_out   (last_out),
        .error_out  (error_out),
        .slot_idx   (slot_idx)
    );

    // an error beat always closes the stream with zero data
    a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_out) |-> (last_out && data_out == 8'h00))
        else $error("error beat without last or with data");

    // slot walk never runs past the job's final result
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (slot_idx <= head_job.last_idx))
        else $error("slot index beyond job");

    // a job at the head stays while the output register is stalled
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !empty && !pop) |=> head_valid)
        else $error("job lost during output stall");

endmodule
